/* sv/rmtw_pkg.sv */
package rmtw_pkg;

   // Operation carried by one request transaction.
   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_ADVANCE = 2'd1,
      MODE_RESTART = 2'd2,
      MODE_TRACE   = 2'd3
   } mode_type;

   // Kind of one cell row of the model.
   typedef enum logic [1:0] {
      KIND_BACKGROUND = 2'd0,
      KIND_MATCH      = 2'd1,
      KIND_INSERTION  = 2'd2,
      KIND_DELETION   = 2'd3
   } kind_type;

   // Register indexes of the write port.
   localparam logic [1:0] CSR_MAX_PERIOD     = 2'd0;
   localparam logic [1:0] CSR_MAX_INSERTIONS = 2'd1;
   localparam logic [1:0] CSR_MAX_DELETIONS  = 2'd2;
   localparam logic [1:0] CSR_MATRIX_LENGTH  = 2'd3;

   // Register values after reset.
   localparam logic [4:0] RESET_MAX_PERIOD     = 5'd16;
   localparam logic [2:0] RESET_MAX_INSERTIONS = 3'd0;
   localparam logic [2:0] RESET_MAX_DELETIONS  = 3'd0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic build_start;
      logic build_run;
      logic trace_load;
      logic emit_row;
      logic emit_parent;
      logic emit_error;
      logic step;
      logic load_back;
      logic back_dec;
      logic row_from_store;
      logic row_from_parent;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic build_done;
      logic tb_error;
      logic cell_indel;
      logic rem_zero;
      logic back_one;
      logic out_free;
   } status_type;

endpackage

/* sv/repeat_model_traceback_window_unit.sv */
// Traceback window for a repeat-period model. Column writes, column advances and
// restarts are taken one per cycle while the request port is open, and give no
// result. A traceback request walks back window_length+1 positions from the newest
// column and returns one result per position, position 0 last with last set; a bad
// window or start row returns one error result. The walk starts with the range
// check. A match or background position goes through a cell table read, a store
// read and a row update; an expanded insertion or deletion run takes a decision on
// the indel cell, then emits its positions one by one, then reads its parent from
// the table. The request port is closed for the whole walk; it opens again once the
// last result is in the output register, whether or not that result has been taken
// yet. After reset and after every register write the cell table is rebuilt, one
// row a cycle; requests are held off during that rebuild.
module repeat_model_traceback_window_unit #(
   parameter int LENGTH     = 64,
   parameter int MAX_PERIOD = 16,
   parameter int MAX_INDEL  = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [4:0] req_order_slot,
   input  logic [7:0] req_entry_row,
   input  logic [5:0] req_window_length,
   input  logic [7:0] req_start_row,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_trace_position,
   output logic [7:0] rsp_trace_row,
   output logic       rsp_last,
   output logic       rsp_error,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_wdata
);
   import rmtw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   rmtw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .csr_we    (csr_we),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Store, cell table and walk registers.
   rmtw_datapath #(
      .LENGTH     (LENGTH),
      .MAX_PERIOD (MAX_PERIOD),
      .MAX_INDEL  (MAX_INDEL)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_mode           (req_mode),
      .req_order_slot     (req_order_slot),
      .req_entry_row      (req_entry_row),
      .req_window_length  (req_window_length),
      .req_start_row      (req_start_row),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_trace_position (rsp_trace_position),
      .rsp_trace_row      (rsp_trace_row),
      .rsp_last           (rsp_last),
      .rsp_error          (rsp_error)
   );

endmodule

/* sv/rmtw_ctrl.sv */
module rmtw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_mode,
   input  logic                  csr_we,
   input  rmtw_pkg::status_type  status,
   output logic                  req_ready,
   output rmtw_pkg::cmd_type     cmd
);
   import rmtw_pkg::*;

   typedef enum logic [3:0] {
      S_BSTART,
      S_BUILD,
      S_IDLE,
      S_CHECK,
      S_DECIDE,
      S_STORE,
      S_FETCH,
      S_PARENT,
      S_ROW
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_BSTART: begin
            cmd.build_start = 1'b1;
            state_in        = S_BUILD;
         end
         S_BUILD: begin
            cmd.build_run = 1'b1;
            if (status.build_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = !csr_we;
            if (req_valid && !csr_we) begin
               cmd.accept = 1'b1;
               if (req_mode == MODE_TRACE) begin
                  cmd.trace_load = 1'b1;
                  state_in       = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (status.tb_error) begin
               if (status.out_free) begin
                  cmd.emit_error = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.cell_indel) begin
               cmd.load_back = 1'b1;
               state_in      = S_PARENT;
            end else if (status.out_free) begin
               cmd.emit_row = 1'b1;
               if (status.rem_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.step = 1'b1;
                  state_in = S_STORE;
               end
            end
         end
         S_STORE: begin
            cmd.row_from_store = 1'b1;
            state_in           = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_DECIDE;
         end
         S_PARENT: begin
            if (status.out_free) begin
               cmd.emit_parent = 1'b1;
               if (status.rem_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.step     = 1'b1;
                  cmd.back_dec = 1'b1;
                  if (status.back_one) begin
                     state_in = S_ROW;
                  end
               end
            end
         end
         S_ROW: begin
            if (status.out_free) begin
               cmd.emit_row = 1'b1;
               if (status.rem_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.step            = 1'b1;
                  cmd.row_from_parent = 1'b1;
                  state_in            = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_BSTART;
         end
      endcase
      // A register write rebuilds the cell table.
      if (csr_we) begin
         state_in = S_BSTART;
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BSTART;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/rmtw_datapath.sv */
module rmtw_datapath #(
   parameter int LENGTH     = 64,
   parameter int MAX_PERIOD = 16,
   parameter int MAX_INDEL  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rmtw_pkg::cmd_type     cmd,
   output rmtw_pkg::status_type  status,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [6:0]            csr_wdata,
   input  logic [1:0]            req_mode,
   input  logic [4:0]            req_order_slot,
   input  logic [7:0]            req_entry_row,
   input  logic [5:0]            req_window_length,
   input  logic [7:0]            req_start_row,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [5:0]            rsp_trace_position,
   output logic [7:0]            rsp_trace_row,
   output logic                  rsp_last,
   output logic                  rsp_error
);
   import rmtw_pkg::*;

   localparam int SLOTS       = MAX_PERIOD + 1;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int COL_W       = $clog2(LENGTH);
   localparam int ORD_W       = $clog2(MAX_PERIOD);
   localparam int IND_W       = $clog2(MAX_INDEL + 2);
   localparam int SUB_W       = $clog2(2 * MAX_INDEL + 2);
   localparam int BACK_W      = ORD_W + 1;
   localparam int CELLS       = MAX_PERIOD * (1 + 2 * MAX_INDEL) + 1;
   localparam int TBL_DEPTH   = (CELLS > 256) ? 256 : CELLS;
   localparam int TBL_AW      = $clog2(TBL_DEPTH);
   localparam int CNT_W       = $clog2(CELLS + 1);
   localparam int ENT_W       = 2 + ORD_W + IND_W + 8;
   localparam int STORE_DEPTH = LENGTH << SLOT_W;

   // Configuration registers.
   logic [4:0] period_ff;
   logic [2:0] ins_ff;
   logic [2:0] del_ff;
   logic [6:0] mlen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= RESET_MAX_PERIOD;
         ins_ff    <= RESET_MAX_INSERTIONS;
         del_ff    <= RESET_MAX_DELETIONS;
         mlen_ff   <= 7'(LENGTH);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_PERIOD: begin
               period_ff <= (int'(csr_wdata[4:0]) > MAX_PERIOD) ? 5'(MAX_PERIOD)
                                                                 : csr_wdata[4:0];
            end
            CSR_MAX_INSERTIONS: begin
               ins_ff <= (int'(csr_wdata[2:0]) > MAX_INDEL) ? 3'(MAX_INDEL) : csr_wdata[2:0];
            end
            CSR_MAX_DELETIONS: begin
               del_ff <= (int'(csr_wdata[2:0]) > MAX_INDEL) ? 3'(MAX_INDEL) : csr_wdata[2:0];
            end
            CSR_MATRIX_LENGTH: begin
               if (csr_wdata < 7'd2) begin
                  mlen_ff <= 7'd2;
               end else if (int'(csr_wdata) > LENGTH) begin
                  mlen_ff <= 7'(LENGTH);
               end else begin
                  mlen_ff <= csr_wdata;
               end
            end
            default: begin
               mlen_ff <= mlen_ff;
            end
         endcase
      end
   end

   // Cell table build sequencer: one row per cycle, order by order.
   logic [4:0]       p_sat;
   logic [2:0]       mi_sat;
   logic [2:0]       md_sat;
   logic [2:0]       ni;
   logic [2:0]       nd;
   logic [4:0]       bo_ff;
   logic [SUB_W-1:0] sub_ff;
   logic [CNT_W-1:0] bidx_ff;
   logic [7:0]       bm_ff;
   logic [SUB_W-1:0] sub_last;
   logic             build_done;
   logic [ENT_W-1:0] build_entry;
   logic [ENT_W-1:0] tbl_mem [0:TBL_DEPTH-1];
   logic [ENT_W-1:0] tbl_q;

   always_comb begin
      p_sat      = (int'(period_ff) > MAX_PERIOD) ? 5'(MAX_PERIOD) : period_ff;
      mi_sat     = (int'(ins_ff) > MAX_INDEL) ? 3'(MAX_INDEL) : ins_ff;
      md_sat     = (int'(del_ff) > MAX_INDEL) ? 3'(MAX_INDEL) : del_ff;
      ni         = (5'(mi_sat) >= bo_ff) ? 3'(bo_ff - 5'd1) : mi_sat;
      nd         = (5'(md_sat) >= bo_ff) ? 3'(bo_ff - 5'd1) : md_sat;
      sub_last   = SUB_W'(ni) + SUB_W'(nd);
      build_done = bo_ff >= p_sat;
      if (sub_ff == '0) begin
         build_entry = {KIND_MATCH, ORD_W'(bo_ff), IND_W'(0), 8'd0};
      end else if (int'(sub_ff) <= int'(ni)) begin
         build_entry = {KIND_INSERTION, ORD_W'(bo_ff), IND_W'(sub_ff), bm_ff};
      end else begin
         build_entry = {KIND_DELETION, ORD_W'(bo_ff), IND_W'(sub_ff - SUB_W'(ni)), bm_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build_start) begin
         bo_ff   <= 5'd1;
         sub_ff  <= '0;
         bidx_ff <= CNT_W'(1);
         bm_ff   <= 8'd0;
      end else if (cmd.build_run && !build_done) begin
         if (sub_ff == '0) begin
            bm_ff <= 8'(bidx_ff);
         end
         if (sub_ff == sub_last) begin
            sub_ff <= '0;
            bo_ff  <= bo_ff + 5'd1;
         end else begin
            sub_ff <= sub_ff + SUB_W'(1);
         end
         bidx_ff <= bidx_ff + CNT_W'(1);
      end
   end

   // Cell table memory, read every cycle at the current row.
   logic [7:0] row_ff;

   always_ff @(posedge clock) begin
      if (cmd.build_run && !build_done && int'(bidx_ff) < TBL_DEPTH) begin
         tbl_mem[bidx_ff[TBL_AW-1:0]] <= build_entry;
      end
      tbl_q <= tbl_mem[row_ff[TBL_AW-1:0]];
   end

   // Decode of the current cell; row zero and rows past the table are background.
   logic             in_tbl;
   logic             bg;
   kind_type         cell_kind;
   logic [ORD_W-1:0] cell_order;
   logic [IND_W-1:0] cell_indel;
   logic [7:0]       cell_parent;
   logic [BACK_W-1:0] back_init;

   always_comb begin
      in_tbl      = int'(row_ff) < int'(bidx_ff);
      bg          = !in_tbl || (row_ff == 8'd0);
      cell_kind   = bg ? KIND_BACKGROUND : kind_type'(tbl_q[ENT_W-1 -: 2]);
      cell_order  = bg ? '0 : tbl_q[ENT_W-3 -: ORD_W];
      cell_indel  = bg ? '0 : tbl_q[8 +: IND_W];
      cell_parent = bg ? 8'd0 : tbl_q[7:0];
      back_init   = BACK_W'(cell_order) +
                    ((cell_kind == KIND_INSERTION) ? BACK_W'(cell_indel) : BACK_W'(0));
   end

   // Traceback store; column zero has per-slot valid bits.
   logic [7:0]         store_mem [0:STORE_DEPTH-1];
   logic [7:0]         store_q;
   logic               zero_q;
   logic [SLOTS-1:0]   valid0_ff;
   logic [COL_W-1:0]   wcol_ff;
   logic [COL_W-1:0]   ncol_ff;
   logic [COL_W-1:0]   pos_ff;
   logic [SLOT_W-1:0]  wr_slot;
   logic [SLOT_W-1:0]  rd_slot;
   logic               do_write;

   assign wr_slot  = SLOT_W'(req_order_slot);
   assign rd_slot  = SLOT_W'(cell_order);
   assign do_write = cmd.accept && (req_mode == MODE_WRITE) &&
                     (int'(req_order_slot) <= MAX_PERIOD);

   always_ff @(posedge clock) begin
      if (do_write) begin
         store_mem[{wcol_ff, wr_slot}] <= req_entry_row;
      end
      store_q <= store_mem[{pos_ff, rd_slot}];
      zero_q  <= (pos_ff == '0) && !valid0_ff[rd_slot];
   end

   // Column indices and column-zero valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= '0;
         wcol_ff   <= COL_W'(1);
         ncol_ff   <= '0;
      end else if (cmd.accept) begin
         case (req_mode)
            MODE_WRITE: begin
               if (do_write && wcol_ff == '0) begin
                  valid0_ff[wr_slot] <= 1'b1;
               end
            end
            MODE_ADVANCE: begin
               ncol_ff <= wcol_ff;
               if (int'(wcol_ff) + 1 >= int'(mlen_ff)) begin
                  wcol_ff <= '0;
               end else begin
                  wcol_ff <= wcol_ff + COL_W'(1);
               end
            end
            MODE_RESTART: begin
               valid0_ff <= '0;
               wcol_ff   <= COL_W'(1);
               ncol_ff   <= '0;
            end
            default: begin
               ncol_ff <= ncol_ff;
            end
         endcase
      end
   end

   // Walk registers.
   logic [5:0]        rem_ff;
   logic [BACK_W-1:0] back_ff;

   always_ff @(posedge clock) begin
      if (cmd.trace_load) begin
         row_ff <= req_start_row;
         rem_ff <= req_window_length;
         pos_ff <= ncol_ff;
      end else begin
         if (cmd.step) begin
            rem_ff <= rem_ff - 6'd1;
            pos_ff <= (pos_ff == '0) ? COL_W'(mlen_ff - 7'd1) : pos_ff - COL_W'(1);
         end
         if (cmd.row_from_store) begin
            row_ff <= zero_q ? 8'd0 : store_q;
         end else if (cmd.row_from_parent) begin
            row_ff <= cell_parent;
         end
      end
      if (cmd.load_back) begin
         back_ff <= back_init;
      end else if (cmd.back_dec) begin
         back_ff <= back_ff - BACK_W'(1);
      end
   end

   // Output register for result transactions.
   logic       rsp_valid_ff;
   logic [5:0] rsp_pos_ff;
   logic [7:0] rsp_row_ff;
   logic       rsp_last_ff;
   logic       rsp_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_row || cmd.emit_parent || cmd.emit_error) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_error) begin
         rsp_pos_ff   <= 6'd0;
         rsp_row_ff   <= 8'd0;
         rsp_last_ff  <= 1'b1;
         rsp_error_ff <= 1'b1;
      end else if (cmd.emit_row || cmd.emit_parent) begin
         rsp_pos_ff   <= rem_ff;
         rsp_row_ff   <= cmd.emit_parent ? cell_parent : row_ff;
         rsp_last_ff  <= rem_ff == 6'd0;
         rsp_error_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trace_position = rsp_pos_ff;
   assign rsp_trace_row      = rsp_row_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_error          = rsp_error_ff;

   // Status toward the controller.
   always_comb begin
      status.build_done = build_done;
      status.tb_error   = (int'(rem_ff) > int'(mlen_ff)) || !in_tbl;
      status.cell_indel = (cell_kind == KIND_INSERTION) || (cell_kind == KIND_DELETION);
      status.rem_zero   = rem_ff == 6'd0;
      status.back_one   = back_ff == BACK_W'(1);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

/* sv/rmtw_checker.sv */
module rmtw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_mode,
   input logic       rsp_valid,
   input logic [5:0] rsp_trace_position,
   input logic [7:0] rsp_trace_row,
   input logic       rsp_last,
   input logic       rsp_error
);
   import rmtw_pkg::*;

   // An error transaction is always the last of its run.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last)
      else $error("error result without last");

   // An error transaction carries position and row zero.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> (rsp_trace_position == 6'd0) && (rsp_trace_row == 8'd0))
      else $error("error result with nonzero payload");

   // A run always ends at forward position zero.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_trace_position == 6'd0)
      else $error("last result not at position zero");

   // A traceback request closes the request port for the walk.
   a_trace_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_TRACE) |=> !req_ready)
      else $error("request taken during a traceback");

endmodule

bind repeat_model_traceback_window_unit rmtw_checker u_rmtw_checker (.*);

/* tb/sv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rmtw_pkg::*;

   localparam int LENGTH     = 64;
   localparam int MAX_PERIOD = 16;
   localparam int MAX_INDEL  = 4;
   localparam int SLOTS      = MAX_PERIOD + 1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TARGET_ITEMS = 370;

   // One traceback result as it appears on the response channel.
   typedef struct packed {
      logic [5:0] position;
      logic [7:0] row;
      logic       last;
      logic       error;
   } trace_result_type;

   // One row of the directed stimulus table.
   typedef struct packed {
      mode_type         mode;
      logic [4:0]       slot;
      logic [7:0]       entry;
      logic [5:0]       window;
      logic [7:0]       start;
      logic             typed;
      trace_result_type typed_result;
   } stim_row_type;

   localparam trace_result_type NO_RESULT = '{6'd0, 8'd0, 1'b0, 1'b0};
   localparam trace_result_type BAD_TRACE = '{6'd0, 8'd0, 1'b1, 1'b1};

   // Directed part: reset state, error cases, slot extremes, restart and a short walk.
   localparam int DIRECTED_ROWS = 12;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{MODE_TRACE,   5'd0,  8'd0,   6'd0, 8'd0,   1'b1, '{6'd0, 8'd0, 1'b1, 1'b0}},
      '{MODE_TRACE,   5'd0,  8'd0,   6'd0, 8'd3,   1'b1, '{6'd0, 8'd3, 1'b1, 1'b0}},
      '{MODE_TRACE,   5'd0,  8'd0,   6'd0, 8'd255, 1'b1, BAD_TRACE},
      '{MODE_TRACE,   5'd0,  8'd0,   6'd0, 8'd16,  1'b1, BAD_TRACE},
      '{MODE_WRITE,   5'd0,  8'd255, 6'd0, 8'd0,   1'b0, NO_RESULT},
      '{MODE_WRITE,   5'd16, 8'd0,   6'd0, 8'd0,   1'b0, NO_RESULT},
      '{MODE_WRITE,   5'd17, 8'd7,   6'd0, 8'd0,   1'b0, NO_RESULT},
      '{MODE_WRITE,   5'd31, 8'd9,   6'd0, 8'd0,   1'b0, NO_RESULT},
      '{MODE_RESTART, 5'd0,  8'd0,   6'd0, 8'd0,   1'b0, NO_RESULT},
      '{MODE_ADVANCE, 5'd0,  8'd0,   6'd0, 8'd0,   1'b0, NO_RESULT},
      '{MODE_TRACE,   5'd0,  8'd0,   6'd1, 8'd0,   1'b0, NO_RESULT},
      '{MODE_TRACE,   5'd0,  8'd0,   6'd0, 8'd15,  1'b0, NO_RESULT}
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   mode_type   req_mode;
   logic [4:0] req_order_slot;
   logic [7:0] req_entry_row;
   logic [5:0] req_window_length;
   logic [7:0] req_start_row;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [5:0] rsp_trace_position;
   logic [7:0] rsp_trace_row;
   logic       rsp_last;
   logic       rsp_error;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [6:0] csr_wdata;

   repeat_model_traceback_window_unit #(
      .LENGTH    (LENGTH),
      .MAX_PERIOD(MAX_PERIOD),
      .MAX_INDEL (MAX_INDEL)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_order_slot    (req_order_slot),
      .req_entry_row     (req_entry_row),
      .req_window_length (req_window_length),
      .req_start_row     (req_start_row),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_trace_position(rsp_trace_position),
      .rsp_trace_row     (rsp_trace_row),
      .rsp_last          (rsp_last),
      .rsp_error         (rsp_error),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Shadow copy of the block: configuration, cell table, store and column indices.
   int unsigned   period_cfg;
   int unsigned   insert_cfg;
   int unsigned   delete_cfg;
   int unsigned   length_cfg;
   kind_type      cell_kind   [256];
   int unsigned   cell_order  [256];
   int unsigned   cell_indel  [256];
   int unsigned   cell_parent [256];
   int unsigned   cell_total;
   logic [7:0]    column_store [LENGTH][SLOTS];
   bit            column_written [LENGTH][SLOTS];
   int unsigned   write_col;
   int unsigned   newest_col;

   trace_result_type walk_results [$];
   trace_result_type pending_results [$];

   int  mismatches;
   int  items_sent;
   int  walks_sent;
   int  results_seen;
   int  cycle_count;
   bit  idle_enabled;
   int  stall_left;

   // Clock.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Rebuild the cell table from the shadow configuration.
   function automatic void build_cells();
      int unsigned slot_idx;
      int unsigned ins_count;
      int unsigned del_count;
      int unsigned match_row;
      slot_idx = 1;
      for (int n = 0; n < 256; n++) begin
         cell_kind[n] = KIND_BACKGROUND;
         cell_order[n] = 0;
         cell_indel[n] = 0;
         cell_parent[n] = 0;
      end
      for (int unsigned o = 1; o < period_cfg; o++) begin
         match_row = slot_idx;
         ins_count = (insert_cfg >= o) ? o - 1 : insert_cfg;
         del_count = (delete_cfg >= o) ? o - 1 : delete_cfg;
         cell_kind[slot_idx] = KIND_MATCH;
         cell_order[slot_idx] = o;
         slot_idx++;
         for (int unsigned j = 0; j < ins_count; j++) begin
            cell_kind[slot_idx] = KIND_INSERTION;
            cell_order[slot_idx] = o;
            cell_indel[slot_idx] = j + 1;
            cell_parent[slot_idx] = match_row;
            slot_idx++;
         end
         for (int unsigned j = 0; j < del_count; j++) begin
            cell_kind[slot_idx] = KIND_DELETION;
            cell_order[slot_idx] = o;
            cell_indel[slot_idx] = j + 1;
            cell_parent[slot_idx] = match_row;
            slot_idx++;
         end
      end
      cell_total = slot_idx;
   endfunction

   function automatic int unsigned column_before(int unsigned col);
      return (col == 0) ? length_cfg - 1 : col - 1;
   endfunction

   // Compute the results of a traceback into walk_results. Returns 1 when the walk
   // would read a store entry that was never written.
   function automatic bit walk_traceback(logic [5:0] window, logic [7:0] start);
      int unsigned col;
      int unsigned row;
      int unsigned i;
      int unsigned back;
      int unsigned ord;
      int unsigned ind;
      int unsigned par;
      kind_type    kind;
      bit          unsafe;
      bit          done;
      walk_results.delete();
      unsafe = 0;
      done = 0;
      if (window > length_cfg || start >= cell_total) begin
         walk_results.push_back(BAD_TRACE);
         return 0;
      end
      col = newest_col;
      row = start;
      i = 0;
      while (i <= window && !done) begin
         if (row < cell_total) begin
            kind = cell_kind[row];
            ord = cell_order[row];
            ind = cell_indel[row];
            par = cell_parent[row];
         end else begin
            kind = KIND_BACKGROUND;
            ord = 0;
            ind = 0;
            par = 0;
         end
         if (kind == KIND_MATCH || kind == KIND_BACKGROUND) begin
            walk_results.push_back('{6'(window - i), 8'(row), 1'b0, 1'b0});
            if (!column_written[col][ord]) unsafe = 1;
            row = column_store[col][ord];
         end else begin
            // An indel run fills its skipped positions with the parent row.
            back = ord + ((kind == KIND_INSERTION) ? ind : 0);
            for (int unsigned j = 0; j < back && !done; j++) begin
               walk_results.push_back('{6'(window - i), 8'(par), 1'b0, 1'b0});
               i++;
               if (i > window) done = 1;
               else col = column_before(col);
            end
            if (!done) begin
               walk_results.push_back('{6'(window - i), 8'(row), 1'b0, 1'b0});
               row = par;
            end
         end
         if (!done) begin
            col = column_before(col);
            i++;
         end
      end
      walk_results[walk_results.size() - 1].last = 1'b1;
      return unsafe;
   endfunction

   // Update the shadow state for one accepted request transaction.
   task automatic apply_request(mode_type mode, logic [4:0] slot, logic [7:0] entry,
                                logic [5:0] window, logic [7:0] start, bit typed,
                                trace_result_type typed_result);
      case (mode)
         MODE_WRITE: begin
            if (slot <= MAX_PERIOD) begin
               column_store[write_col][slot] = entry;
               column_written[write_col][slot] = 1;
            end
         end
         MODE_ADVANCE: begin
            newest_col = write_col;
            write_col = write_col + 1;
            if (write_col >= length_cfg) write_col = 0;
         end
         MODE_RESTART: begin
            write_col = 1;
            newest_col = 0;
            for (int s = 0; s < SLOTS; s++) begin
               column_store[0][s] = 8'd0;
               column_written[0][s] = 1;
            end
         end
         default: begin
            walks_sent++;
            if (typed) begin
               pending_results.push_back(typed_result);
            end else begin
               void'(walk_traceback(window, start));
               foreach (walk_results[n]) pending_results.push_back(walk_results[n]);
            end
         end
      endcase
   endtask

   // Present one request transaction and hold it until the block takes it.
   task automatic send_request(mode_type mode, logic [4:0] slot, logic [7:0] entry,
                               logic [5:0] window, logic [7:0] start, bit typed,
                               trace_result_type typed_result);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_order_slot <= slot;
      req_entry_row <= entry;
      req_window_length <= window;
      req_start_row <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      apply_request(mode, slot, entry, window, start, typed, typed_result);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Write all four registers while the block is idle.
   task automatic write_registers(logic [6:0] period, logic [6:0] inserts,
                                  logic [6:0] deletes, logic [6:0] len);
      logic [6:0] values [4];
      int unsigned v;
      values = '{period, inserts, deletes, len};
      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      for (int r = 0; r < 4; r++) begin
         csr_we <= 1'b1;
         csr_index <= 2'(r);
         csr_wdata <= values[r];
         @(posedge clock);
         case (2'(r))
            CSR_MAX_PERIOD: begin
               v = values[r] & 7'h1F;
               period_cfg = (v > MAX_PERIOD) ? MAX_PERIOD : v;
            end
            CSR_MAX_INSERTIONS: begin
               v = values[r] & 7'h07;
               insert_cfg = (v > MAX_INDEL) ? MAX_INDEL : v;
            end
            CSR_MAX_DELETIONS: begin
               v = values[r] & 7'h07;
               delete_cfg = (v > MAX_INDEL) ? MAX_INDEL : v;
            end
            default: begin
               v = values[r];
               length_cfg = (v < 2) ? 2 : (v > LENGTH) ? LENGTH : v;
            end
         endcase
         build_cells();
      end
      csr_we <= 1'b0;
   endtask

   // Pick a stored row: mostly a row of the cell table, now and then anything.
   function automatic logic [7:0] pick_row();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, cell_total - 1));
   endfunction

   // One random step: a column fill, a traceback, or noise.
   task automatic random_step();
      int unsigned choice;
      logic [5:0]  window;
      logic [7:0]  start;
      int unsigned cap;
      choice = $urandom_range(0, 99);
      if (choice < 55) begin
         // Fill the orders the table uses, then move on to the next column.
         for (int unsigned s = 0; s < period_cfg; s++)
            send_request(MODE_WRITE, 5'(s), pick_row(), 6'($urandom), 8'($urandom),
                         0, NO_RESULT);
         send_request(MODE_ADVANCE, 5'($urandom), 8'($urandom), 6'($urandom),
                      8'($urandom), 0, NO_RESULT);
      end else if (choice < 85) begin
         cap = (length_cfg < 10) ? length_cfg : 10;
         window = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, cap));
         start = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(0, cell_total - 1));
         if (walk_traceback(window, start)) window = 6'd0;
         if (walk_traceback(window, start))
            send_request(MODE_WRITE, 5'($urandom), 8'($urandom), window, start, 0, NO_RESULT);
         else
            send_request(MODE_TRACE, 5'($urandom), 8'($urandom), window, start, 0, NO_RESULT);
      end else if (choice < 93) begin
         send_request(MODE_WRITE, 5'($urandom), 8'($urandom), 6'($urandom), 8'($urandom),
                      0, NO_RESULT);
      end else if (choice < 98) begin
         send_request(MODE_ADVANCE, 5'($urandom), 8'($urandom), 6'($urandom),
                      8'($urandom), 0, NO_RESULT);
      end else begin
         send_request(MODE_RESTART, 5'($urandom), 8'($urandom), 6'($urandom),
                      8'($urandom), 0, NO_RESULT);
      end
   endtask

   // Response side: random stall bursts while idling is enabled.
   always @(posedge clock) begin
      if (reset || !idle_enabled) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= (stall_left == 1);
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(1, 12);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      trace_result_type seen;
      trace_result_type wanted;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_trace_position, rsp_trace_row, rsp_last, rsp_error};
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: position %0d row %0d last %0b error %0b",
                        seen.position, seen.row, seen.last, seen.error);
         end else begin
            wanted = pending_results.pop_front();
            if (seen !== wanted) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: expected pos %0d row %0d last %0b err %0b,",
                            " got pos %0d row %0d last %0b err %0b"},
                           wanted.position, wanted.row, wanted.last, wanted.error,
                           seen.position, seen.row, seen.last, seen.error);
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Main sequence.
   initial begin
      logic [6:0] phase_cfg [8][4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_WRITE;
      req_order_slot = '0;
      req_entry_row = '0;
      req_window_length = '0;
      req_start_row = '0;
      csr_we = 1'b0;
      csr_index = CSR_MAX_PERIOD;
      csr_wdata = '0;
      mismatches = 0;
      items_sent = 0;
      walks_sent = 0;
      results_seen = 0;
      idle_enabled = 1;
      period_cfg = RESET_MAX_PERIOD;
      insert_cfg = RESET_MAX_INSERTIONS;
      delete_cfg = RESET_MAX_DELETIONS;
      length_cfg = LENGTH;
      write_col = 1;
      newest_col = 0;
      for (int c = 0; c < LENGTH; c++)
         for (int s = 0; s < SLOTS; s++) begin
            column_store[c][s] = 8'd0;
            column_written[c][s] = (c == 0);
         end
      build_cells();

      // Settings per phase, out-of-range values among them to check saturation.
      phase_cfg = '{
         '{7'd4,  7'd2, 7'd2, 7'd8},
         '{7'd2,  7'd0, 7'd0, 7'd2},
         '{7'd16, 7'd4, 7'd4, 7'd64},
         '{7'd31, 7'd7, 7'd7, 7'd127},
         '{7'd5,  7'd4, 7'd1, 7'd0},
         '{7'd8,  7'd1, 7'd3, 7'd5},
         '{7'd6,  7'd3, 7'd4, 7'd1},
         '{7'd7,  7'd2, 7'd2, 7'd12}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[n])
         send_request(DIRECTED[n].mode, DIRECTED[n].slot, DIRECTED[n].entry,
                      DIRECTED[n].window, DIRECTED[n].start, DIRECTED[n].typed,
                      DIRECTED[n].typed_result);

      for (int p = 0; p < 8; p++) begin
         write_registers(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                         phase_cfg[p][3]);
         if (p == 7) idle_enabled = 0;
         while (items_sent < DIRECTED_ROWS + (p + 1) * (TARGET_ITEMS - DIRECTED_ROWS) / 8) begin
            random_step();
            // In phase 3, with walks_sent a multiple of 7, let all results drain.
            if (p == 3 && walks_sent % 7 == 0 && pending_results.size() != 0) begin
               req_valid <= 1'b0;
               wait_drained();
            end
         end
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (50) @(posedge clock);
      if (pending_results.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", pending_results.size());
      end
      $display("covered %0d request transactions, %0d tracebacks, %0d result transactions",
               items_sent, walks_sent, results_seen);
      $display("over eight register settings including saturated and minimum values");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
